@@ hw/rtl/sha1md_pkg.sv @@
// Package for the SHA-1 message digest block.
// Holds the channel word types, the initial hash values and the round constants.
// No dependencies.
package sha1md_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } digest_word_t;

    localparam int NUM_HASH_WORDS = 5;
    localparam int NUM_BLOCK_WORDS = 16;
    localparam int NUM_ROUNDS = 80;

    localparam logic [31:0] SHA1_IV [NUM_HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

@@ hw/rtl/sha1_message_digest.sv @@
// SHA-1 message digest, top level.
// Block buffer in a 16x32 synchronous memory, one shared round unit.
// Depends on sha1md_pkg.
//
// Usage:
//   msg channel: one word per item, an optional message byte plus an
//   end-of-message flag. digest channel: five 32-bit digest words per
//   message, word_number 0..4, last_word set on the fifth.
//   While the block waits for input, a byte is taken every cycle. The
//   byte that fills a 64-byte block holds msg_stall high through one
//   memory prefetch, 80 rounds of the shared round unit and a fold of
//   the result into the chaining words.
//   At message end the padding pass writes the rest of the block, one
//   memory word a cycle (1 to 16 words), then the block is compressed;
//   a tail of 56 or more bytes adds a second pass of 16 words and compression.
//   The five digest words then leave one per cycle from an output
//   register; a stall on digest holds the current word and the block.
//   msg_stall stays high until the last digest word is taken, at which
//   point the chaining words, byte count and bit count reload.
//   Reset (rst_n low, asynchronous) loads the initial hash values and
//   clears all counters; the memory contents are not cleared.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_word_t    msg,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_word_t digest
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    state_t       state_reg, state_next;
    logic [5:0]   count_reg, count_next;
    logic [63:0]  bits_reg, bits_next;
    logic [31:0]  word_reg, word_next;
    logic [31:0]  h_reg [NUM_HASH_WORDS];
    logic [31:0]  h_next [NUM_HASH_WORDS];
    logic [31:0]  w_reg [NUM_BLOCK_WORDS];
    logic [31:0]  w_next [NUM_BLOCK_WORDS];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [6:0]   round_reg, round_next;
    logic [3:0]   pad_reg, pad_next;
    logic         closing_reg, closing_next;
    logic         padded_reg, padded_next;
    logic         second_reg, second_next;
    logic [2:0]   j_reg, j_next;
    logic         out_valid_reg, out_valid_next;
    digest_word_t out_reg, out_next;

    logic [31:0]  mem [NUM_BLOCK_WORDS];
    logic [31:0]  rdata_reg;
    logic         mem_we;
    logic [3:0]   mem_waddr;
    logic [31:0]  mem_wdata;
    logic [3:0]   mem_raddr;

    logic [31:0]  byte_word;
    logic [31:0]  pad_word;
    logic [31:0]  pad_data;
    logic         spill;
    logic         len_block;
    logic [31:0]  wt;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  t_val;
    logic         out_fire;

    assign msg_stall    = (state_reg != S_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;
    assign out_fire     = out_valid_reg && !digest_stall;

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    byte_word = {msg.message_byte, 24'h0};
            2'd1:    byte_word = {word_reg[31:24], msg.message_byte, 16'h0};
            2'd2:    byte_word = {word_reg[31:16], msg.message_byte, 8'h0};
            default: byte_word = {word_reg[31:8], msg.message_byte};
        endcase
        case (count_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {word_reg[31:24], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {word_reg[31:16], PAD_BYTE, 8'h0};
            default: pad_word = {word_reg[31:8], PAD_BYTE};
        endcase
    end

    assign spill     = (count_reg >= 6'd56);
    assign len_block = second_reg || !spill;

    always_comb
    begin
        if (!second_reg && (pad_reg == count_reg[5:2]))
        begin
            pad_data = pad_word;
        end
        else if (len_block && (pad_reg == 4'd14))
        begin
            pad_data = bits_reg[63:32];
        end
        else if (len_block && (pad_reg == 4'd15))
        begin
            pad_data = bits_reg[31:0];
        end
        else
        begin
            pad_data = 32'h0;
        end
    end

    // round unit
    always_comb
    begin
        if (round_reg < 7'd16)
        begin
            wt = rdata_reg;
        end
        else
        begin
            wt = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
            wt = {wt[30:0], wt[31]};
        end
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = SHA1_K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA1_K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = SHA1_K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA1_K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + wt;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bits_next      = bits_reg;
        word_next      = word_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        round_next     = round_reg;
        pad_next       = pad_reg;
        closing_next   = closing_reg;
        padded_next    = padded_reg;
        second_next    = second_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[5:2];
        mem_wdata      = byte_word;
        mem_raddr      = 4'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_present)
                    begin
                        word_next  = byte_word;
                        count_next = count_reg + 6'd1;
                        bits_next  = bits_reg + 64'd8;
                        mem_we     = (count_reg[1:0] == 2'd3);
                    end
                    closing_next = msg.end_of_message;
                    pad_next     = count_next[5:2];
                    if (msg.byte_present && (count_reg == 6'd63))
                    begin
                        state_next = S_LOAD;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = pad_reg;
                mem_wdata = pad_data;
                pad_next  = pad_reg + 4'd1;
                if (pad_reg == 4'd15)
                begin
                    padded_next = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                mem_raddr  = 4'd0;
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                e_next     = h_reg[4];
                round_next = 7'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                mem_raddr = round_reg[3:0] + 4'd1;
                for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[NUM_BLOCK_WORDS - 1] = wt;
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(NUM_ROUNDS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (!closing_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!padded_reg)
                begin
                    pad_next   = count_reg[5:2];
                    state_next = S_PAD;
                end
                else if (spill && !second_reg)
                begin
                    second_next = 1'b1;
                    pad_next    = 4'd0;
                    state_next  = S_PAD;
                end
                else
                begin
                    j_next     = 3'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    if (j_reg < 3'(NUM_HASH_WORDS))
                    begin
                        out_valid_next       = 1'b1;
                        out_next.digest_word = h_reg[j_reg];
                        out_next.word_number = j_reg;
                        out_next.last_word   = (j_reg == 3'(NUM_HASH_WORDS - 1));
                        j_next               = j_reg + 3'd1;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        h_next         = SHA1_IV;
                        count_next     = 6'd0;
                        bits_next      = 64'd0;
                        closing_next   = 1'b0;
                        padded_next    = 1'b0;
                        second_next    = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 6'd0;
            bits_reg      <= 64'd0;
            h_reg         <= SHA1_IV;
            round_reg     <= 7'd0;
            pad_reg       <= 4'd0;
            closing_reg   <= 1'b0;
            padded_reg    <= 1'b0;
            second_reg    <= 1'b0;
            j_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bits_reg      <= bits_next;
            h_reg         <= h_next;
            round_reg     <= round_next;
            pad_reg       <= pad_next;
            closing_reg   <= closing_next;
            padded_reg    <= padded_next;
            second_reg    <= second_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        w_reg    <= w_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        out_reg  <= out_next;
    end

    // block buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        !msg_stall |-> !digest_valid)
        else $error("digest word pending while input is open");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && digest.last_word) |=> !digest_valid)
        else $error("digest word after the last word");

    a_word_number_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.word_number <= 3'(NUM_HASH_WORDS - 1)))
        else $error("digest word number out of range");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (round_reg < 7'(NUM_ROUNDS)))
        else $error("round counter out of range");

    a_output_only_closing: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (closing_reg && padded_reg))
        else $error("digest word before padding finished");

endmodule

@@ sim/sha1_message_digest_tb.sv @@
// Testbench for sha1_message_digest: streams messages byte by byte, predicts each
// digest with an in-bench SHA-1 and checks every digest word in order.
// Depends on sha1md_pkg and the sha1_message_digest RTL.
module sha1_message_digest_tb;

    import sha1md_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_word_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_word_t digest;

    sha1_message_digest u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("sha1_message_digest verification failed");
        $finish;
    end

    // Digest predictor state
    logic [31:0]  chain [NUM_HASH_WORDS];
    logic [31:0]  blk [NUM_BLOCK_WORDS];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_word_t pending_digest [$];

    int  fail_count = 0;
    int  bytes_sent = 0;
    int  messages_sent = 0;
    bit  idle_on = 1'b0;
    int  stall_hold = 0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic load_iv();
        for (int i = 0; i < NUM_HASH_WORDS; i++)
        begin
            chain[i] = SHA1_IV[i];
        end
        fill = 0;
        bit_len = '0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [NUM_ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < NUM_ROUNDS; r++)
        begin
            if (r < 16)
                w[r] = blk[r];
            else
                w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < NUM_ROUNDS; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = SHA1_K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = SHA1_K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = SHA1_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = SHA1_K3;
            end
            t = rotl(a, 5) + f + e + k + w[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic place_byte(input int unsigned pos, input logic [7:0] value);
        int unsigned sh;
        sh = (3 - pos % 4) * 8;
        if (pos % 4 == 0)
            blk[pos / 4] = 32'(value) << sh;
        else
            blk[pos / 4] |= 32'(value) << sh;
    endtask

    task automatic sha1_absorb(input msg_word_t m);
        digest_word_t dw;
        int unsigned  n;
        if (m.byte_present)
        begin
            place_byte(fill, m.message_byte);
            bit_len += 64'd8;
            fill = (fill + 1) % 64;
            if (fill == 0)
                sha1_compress();
        end
        if (!m.end_of_message)
            return;
        n = fill;
        place_byte(n, PAD_BYTE);
        for (int i = n / 4 + 1; i < NUM_BLOCK_WORDS; i++)
        begin
            blk[i] = '0;
        end
        // no room for the length field: spill into a second block
        if (n >= 56)
        begin
            sha1_compress();
            for (int i = 0; i < NUM_BLOCK_WORDS; i++)
            begin
                blk[i] = '0;
            end
        end
        blk[14] = bit_len[63:32];
        blk[15] = bit_len[31:0];
        sha1_compress();
        for (int j = 0; j < NUM_HASH_WORDS; j++)
        begin
            dw.digest_word = chain[j];
            dw.word_number = 3'(j);
            dw.last_word   = (j == NUM_HASH_WORDS - 1);
            pending_digest = {pending_digest, dw};
        end
        load_iv();
    endtask

    // Digest-side stall bursts
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            digest_stall <= 1'b1;
            stall_hold   <= $urandom_range(0, 2);
        end
        else
        begin
            digest_stall <= 1'b0;
        end
    end

    // Digest word checker
    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (pending_digest.size() == 0)
            begin
                $error("unexpected digest word %h", digest.digest_word);
                fail_count++;
            end
            else
            begin
                want = pending_digest.pop_front();
                if (digest.digest_word !== want.digest_word)
                begin
                    $error("digest_word expected %h actual %h",
                           want.digest_word, digest.digest_word);
                    fail_count++;
                end
                if (digest.word_number !== want.word_number)
                begin
                    $error("word_number expected %0d actual %0d",
                           want.word_number, digest.word_number);
                    fail_count++;
                end
                if (digest.last_word !== want.last_word)
                begin
                    $error("last_word expected %0b actual %0b",
                           want.last_word, digest.last_word);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] value, input logic present, input logic eom);
        msg_word_t w;
        w.message_byte   = value;
        w.byte_present   = present;
        w.end_of_message = eom;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= w;
        do
            @(posedge clk);
        while (msg_stall);
        sha1_absorb(w);
        if (present)
            bytes_sent++;
        if (eom)
            messages_sent++;
    endtask

    task automatic send_message(input int len, input bit end_with_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_with_byte && i == len - 1);
        end
        if (!(end_with_byte && len > 0))
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int boundary [5] = '{55, 56, 63, 64, 119};
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 15);
        else if (sel < 8)
            return boundary[$urandom_range(0, 4)];
        else
            return $urandom_range(16, 70);
    endfunction

    task automatic test_empty_message();
        idle_on = 1'b1;
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_abc();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_empty_words_in_message();
        send_word(8'h12, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h34, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h56, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int byte_target);
        while (bytes_sent < byte_target || messages_sent < 10)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_message(pick_length(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (4)
        begin
            send_message($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        load_iv();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_abc();
        test_byte_extremes();
        test_empty_words_in_message();
        test_random_messages(120);
        test_back_to_back();

        msg_valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (fail_count == 0)
            $display("sha1_message_digest verification clean");
        else
            $display("sha1_message_digest verification failed");
        $finish;
    end

endmodule
